// File: rtl/core/dnd_pkg.sv
// ----------------------------------------------------------------------------
// dnd_pkg
// Types, constants and command codes shared by the DNS name decompressor.
// ----------------------------------------------------------------------------
package dnd_pkg;

	localparam int PACKET_BYTES = 512;
	localparam int NAME_LIMIT   = 64;
	localparam int MAX_JUMPS    = 16;

	localparam int ADDR_W  = $clog2(PACKET_BYTES);
	localparam int LEN_W   = 10;                        // packet_length field
	localparam int POS_W   = 14;                        // pointer target width
	localparam int NEXT_W  = 10;                        // next_offset field
	localparam int OLEN_W  = 6;                         // name_length field
	localparam int JMP_W   = $clog2(MAX_JUMPS + 1);
	localparam int CHAR_LIMIT = NAME_LIMIT - 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// command field codes
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_DECODE = 2'd1;
	localparam logic [1:0] CMD_SKIP   = 2'd2;

	localparam logic [7:0] PTR_MARK = 8'hC0;
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_DECODE = 2'd1,
		OP_SKIP   = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [8:0]       write_address;
		logic [7:0]       byte_value;
		logic [8:0]       start_offset;
		logic [LEN_W-1:0] packet_length;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0]        name_char;
		logic              char_valid;
		logic              is_last;
		logic [NEXT_W-1:0] next_offset;
		logic [OLEN_W-1:0] name_length;
	} res_item_t;

	// classified transaction held in the queue
	typedef struct packed {
		op_t              op;
		logic [8:0]       addr;      // write address or start offset
		logic [7:0]       data;
		logic [LEN_W-1:0] plen;      // already saturated to the store size
	} queue_item_t;

endpackage

// File: rtl/core/dnd_front.sv
// ----------------------------------------------------------------------------
// dnd_front
// Accepts command transactions, drops unused ones, saturates the packet
// length and hands the classified item to the queue.
// ----------------------------------------------------------------------------
module dnd_front
	import dnd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_item_t   cmd_data,
	output logic        push,
	output queue_item_t push_item,
	input  logic        queue_full
);

	logic        v_s1;
	queue_item_t item_s1;
	queue_item_t item_d;
	logic        keep;
	logic        accept;

	assign cmd_stall = v_s1 && queue_full;
	assign accept    = cmd_valid && !cmd_stall;
	assign push      = v_s1 && !queue_full;
	assign push_item = item_s1;

	always_comb begin
		keep        = 1'b0;
		item_d.op   = OP_WRITE;
		item_d.addr = cmd_data.write_address;
		item_d.data = cmd_data.byte_value;
		item_d.plen = (cmd_data.packet_length > LEN_W'(PACKET_BYTES)) ?
			LEN_W'(PACKET_BYTES) : cmd_data.packet_length;
		unique case (cmd_data.command)
			CMD_WRITE: begin
				item_d.op = OP_WRITE;
				keep = ({1'b0, cmd_data.write_address} < 10'(PACKET_BYTES));
			end
			CMD_DECODE: begin
				item_d.op   = OP_DECODE;
				item_d.addr = cmd_data.start_offset;
				keep = 1'b1;
			end
			CMD_SKIP: begin
				item_d.op   = OP_SKIP;
				item_d.addr = cmd_data.start_offset;
				keep = 1'b1;
			end
			default: keep = 1'b0;   // unused code, no result
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || push) begin
			v_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: rtl/core/dnd_queue.sv
// ----------------------------------------------------------------------------
// dnd_queue
// Short FIFO between the front and the walker.
// ----------------------------------------------------------------------------
module dnd_queue
	import dnd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  queue_item_t push_item,
	output logic        full,
	input  logic        pop,
	output logic        pop_valid,
	output queue_item_t pop_item
);

	queue_item_t      slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

// File: rtl/core/dnd_back.sv
// ----------------------------------------------------------------------------
// dnd_back
// Packet store and name walker: executes writes, walks names through labels
// and pointers, and drives the result register.
// ----------------------------------------------------------------------------
module dnd_back
	import dnd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  queue_item_t item,
	output logic        pop,
	output logic        res_valid,
	input  logic        res_stall,
	output res_item_t   res_data
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_LEN   = 7'b0000100,
		S_PTR2  = 7'b0001000,
		S_COPY  = 7'b0010000,
		S_SKIP  = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	logic [7:0] mem [PACKET_BYTES];
	logic [7:0] rdata_q;

	state_t             state_q, state_d;
	logic [ADDR_W-1:0]  clr_q, clr_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [LEN_W-1:0]   plen_q, plen_d;
	logic [JMP_W-1:0]   jumps_q, jumps_d;
	logic [OLEN_W-1:0]  olen_q, olen_d;
	logic [7:0]         cnt_q, cnt_d;
	logic [NEXT_W-1:0]  saved_q, saved_d;
	logic               have_saved_q, have_saved_d;
	logic [5:0]         hi_q, hi_d;
	logic               zero_q, zero_d;
	logic [7:0]         pend_q, pend_d;
	logic               pend_v_q, pend_v_d;
	res_item_t          out_q, out_d;
	logic               out_v_q;
	logic               out_push;

	logic               we, re;
	logic [ADDR_W-1:0]  waddr, raddr;
	logic [7:0]         wdata;

	logic               can_push;
	logic               do_chk;
	logic [POS_W-1:0]   chk_pos;
	logic [JMP_W-1:0]   chk_jmp;
	logic [LEN_W-1:0]   chk_len;

	assign can_push  = !out_v_q || !res_stall;
	assign res_valid = out_v_q;
	assign res_data  = out_q;

	always_comb begin
		logic [POS_W-1:0]  p1;
		logic [POS_W-1:0]  plen_ext;
		logic [OLEN_W-1:0] olen1;
		logic [7:0]        cnt1;
		logic [7:0]        chr;
		logic              emit;
		logic              dot;
		logic [NEXT_W-1:0] next;

		state_d      = state_q;
		clr_d        = clr_q;
		pos_d        = pos_q;
		plen_d       = plen_q;
		jumps_d      = jumps_q;
		olen_d       = olen_q;
		cnt_d        = cnt_q;
		saved_d      = saved_q;
		have_saved_d = have_saved_q;
		hi_d         = hi_q;
		zero_d       = zero_q;
		pend_d       = pend_q;
		pend_v_d     = pend_v_q;
		out_d        = out_q;
		out_push     = 1'b0;
		pop          = 1'b0;
		we           = 1'b0;
		re           = 1'b0;
		waddr        = item.addr;
		wdata        = item.data;
		raddr        = '0;
		do_chk       = 1'b0;
		chk_pos      = pos_q;
		chk_jmp      = jumps_q;
		chk_len      = plen_q;
		p1           = pos_q + 1'b1;
		plen_ext     = POS_W'(plen_q);
		olen1        = olen_q;
		cnt1         = cnt_q;
		chr          = rdata_q;
		emit         = 1'b0;
		dot          = 1'b0;
		next         = have_saved_q ? saved_q : pos_q[NEXT_W-1:0];

		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				clr_d = clr_q + 1'b1;
				if (clr_q == ADDR_W'(PACKET_BYTES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					pop          = 1'b1;
					pos_d        = POS_W'(item.addr);
					plen_d       = item.plen;
					jumps_d      = '0;
					olen_d       = '0;
					have_saved_d = 1'b0;
					pend_v_d     = 1'b0;
					case (item.op)
						OP_WRITE: begin
							we = 1'b1;
						end
						OP_DECODE: begin
							do_chk  = 1'b1;
							chk_pos = POS_W'(item.addr);
							chk_jmp = '0;
							chk_len = item.plen;
						end
						OP_SKIP: begin
							if (LEN_W'(item.addr) < item.plen) begin
								re      = 1'b1;
								raddr   = item.addr;
								state_d = S_SKIP;
							end else begin
								pos_d   = POS_W'(item.plen);
								state_d = S_FIN;
							end
						end
						default: ;
					endcase
				end
			end
			S_LEN: begin
				if (can_push) begin
					if (rdata_q == '0) begin
						pos_d   = p1;
						state_d = S_FIN;
					end else if ((rdata_q & PTR_MARK) == PTR_MARK) begin
						if (!have_saved_q) begin
							saved_d      = pos_q[NEXT_W-1:0] + NEXT_W'(2);
							have_saved_d = 1'b1;
						end
						hi_d = rdata_q[5:0];
						if (p1 < POS_W'(PACKET_BYTES)) begin
							re     = 1'b1;
							raddr  = p1[ADDR_W-1:0];
							zero_d = 1'b0;
						end else begin
							zero_d = 1'b1;      // second byte past the store
						end
						state_d = S_PTR2;
					end else begin
						dot   = (olen_q != '0) && (olen_q < OLEN_W'(CHAR_LIMIT));
						emit  = dot;
						chr   = DOT_CHAR;
						olen1 = olen_q + OLEN_W'(dot);
						pos_d = p1;
						cnt_d = rdata_q;
						olen_d = olen1;
						if (p1 < plen_ext && olen1 < OLEN_W'(CHAR_LIMIT)) begin
							re      = 1'b1;
							raddr   = p1[ADDR_W-1:0];
							state_d = S_COPY;
						end else begin
							do_chk  = 1'b1;
							chk_pos = p1;
						end
					end
				end
			end
			S_COPY: begin
				if (can_push) begin
					emit   = 1'b1;
					chr    = rdata_q;
					olen1  = olen_q + 1'b1;
					cnt1   = cnt_q - 1'b1;
					pos_d  = p1;
					cnt_d  = cnt1;
					olen_d = olen1;
					if (cnt1 != '0 && p1 < plen_ext && olen1 < OLEN_W'(CHAR_LIMIT)) begin
						re    = 1'b1;
						raddr = p1[ADDR_W-1:0];
					end else begin
						do_chk  = 1'b1;
						chk_pos = p1;
					end
				end
			end
			S_PTR2: begin
				pos_d   = {hi_q, (zero_q ? 8'h00 : rdata_q)};
				jumps_d = jumps_q + 1'b1;
				do_chk  = 1'b1;
				chk_pos = {hi_q, (zero_q ? 8'h00 : rdata_q)};
				chk_jmp = jumps_q + 1'b1;
			end
			S_SKIP: begin
				if (rdata_q == '0) begin
					pos_d   = p1;
					state_d = S_FIN;
				end else if ((rdata_q & PTR_MARK) == PTR_MARK) begin
					pos_d   = pos_q + POS_W'(2);
					state_d = S_FIN;
				end else begin
					pos_d = p1 + POS_W'(rdata_q);
					if (p1 + POS_W'(rdata_q) < plen_ext) begin
						re    = 1'b1;
						raddr = p1[ADDR_W-1:0] + ADDR_W'(rdata_q);
					end else begin
						pos_d   = plen_ext;
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (can_push) begin
					out_push = 1'b1;
					out_d.is_last     = 1'b1;
					out_d.next_offset = next;
					if (pend_v_q) begin
						out_d.name_char   = pend_q;
						out_d.char_valid  = 1'b1;
						out_d.name_length = olen_q;
					end else begin
						out_d.name_char   = '0;
						out_d.char_valid  = 1'b0;
						out_d.name_length = '0;
					end
					pend_v_d = 1'b0;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// a new character pushes out the one held back, which is not last
		if (emit) begin
			if (pend_v_q) begin
				out_push          = 1'b1;
				out_d.name_char   = pend_q;
				out_d.char_valid  = 1'b1;
				out_d.is_last     = 1'b0;
				out_d.next_offset = '0;
				out_d.name_length = '0;
			end
			pend_d   = chr;
			pend_v_d = 1'b1;
		end

		// loop test of the walk: go on reading a length byte or stop
		if (do_chk) begin
			if (chk_pos < POS_W'(chk_len) && chk_jmp < JMP_W'(MAX_JUMPS)) begin
				re      = 1'b1;
				raddr   = chk_pos[ADDR_W-1:0];
				state_d = S_LEN;
			end else begin
				state_d = S_FIN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			pend_v_q <= pend_v_d;
			if (out_push) begin
				out_v_q <= 1'b1;
			end else if (!res_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		plen_q       <= plen_d;
		jumps_q      <= jumps_d;
		olen_q       <= olen_d;
		cnt_q        <= cnt_d;
		saved_q      <= saved_d;
		have_saved_q <= have_saved_d;
		hi_q         <= hi_d;
		zero_q       <= zero_d;
		pend_q       <= pend_d;
		if (out_push) begin
			out_q <= out_d;
		end
	end

endmodule

// File: rtl/core/dns_name_decompressor_core.sv
// ----------------------------------------------------------------------------
// dns_name_decompressor_core
// DNS name decompressor: loads a packet store byte by byte, walks names with
// compression pointers and streams the dotted name one character per result.
// ----------------------------------------------------------------------------
//
//  channel | signals                        | transaction
//  --------+--------------------------------+-------------------------------
//  cmd     | cmd_valid, cmd_stall, cmd_data | write byte, decode or skip
//  res     | res_valid, res_stall, res_data | one name character or final
//
//  A decode reads each length byte, each character and both bytes of each
//  pointer; a skip reads only the length bytes. The single read port of the
//  packet store paces the walker: it reads one stored byte per cycle while
//  the result register is not held. After reset the store is cleared by a
//  pass over all 512 bytes; commands queue up meanwhile and wait. A held
//  result register or a full queue stalls each side on its own; the last
//  character is held back until the walk ends.
//
module dns_name_decompressor_core
	import dnd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd_data,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_data
);

	logic        q_push;
	queue_item_t q_push_item;
	logic        q_full;
	logic        q_pop;
	logic        q_valid;
	queue_item_t q_item;

	// front: accept, drop unused codes, saturate length
	dnd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_data   (cmd_data),
		.push       (q_push),
		.push_item  (q_push_item),
		.queue_full (q_full)
	);

	// decouples acceptance from the multi-cycle walk
	dnd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	// back: packet store, name walker and result register
	dnd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.pop        (q_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dns_name_decompressor_core. A directed table loads
// a small packet and walks it through the corner cases. Random names follow:
// labels, terminators and compression pointers into earlier names or anywhere, mixed with
// random noise commands. An in-bench walker predicts every result.
// ----------------------------------------------------------------------------
module tb;
	import dnd_pkg::*;

	localparam int          CLK_HALF     = 4;
	localparam int          RESET_CYCLES = 12;
	localparam int          RANDOM_ITEMS = 230;
	localparam int          DRAIN_CYCLES = 300;
	localparam int          CYCLE_LIMIT  = 4000000;
	localparam int          PRINT_CAP    = 40;
	// command 3 has no meaning in the block; it must be dropped silently
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;

	// how a table row gets its expected results
	typedef enum logic [1:0] {
		ROW_MODEL,      // walker predicts
		ROW_TYPED,      // single final result typed in the table
		ROW_SILENT      // no result at all
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		cmd_item_t item;
		res_item_t typed;
	} plan_row_t;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd_data;
	logic      res_valid;
	logic      res_stall;
	res_item_t res_data;

	// walker copy of the packet store and the results it still owes
	logic [7:0] pkt_mem [PACKET_BYTES];
	res_item_t  pending_chars [$];
	plan_row_t  plan [$];

	int  mismatches      = 0;
	int  results_checked = 0;
	int  writes_sent     = 0;
	int  decodes_sent    = 0;
	int  skips_sent      = 0;
	int  longest_name    = 0;
	int  cycle_count     = 0;
	bit  calm            = 1'b0;   // both sides run without gaps while set
	res_item_t want;

	dns_name_decompressor_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------
	task automatic flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_len();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] mem_byte(int unsigned addr);
		return (addr < PACKET_BYTES) ? pkt_mem[addr] : 8'h00;
	endfunction

	// all fields random; callers overwrite the ones the command uses
	function automatic cmd_item_t random_fields();
		cmd_item_t it;
		it.command       = 2'($urandom_range(0, 3));
		it.write_address = 9'($urandom);
		it.byte_value    = 8'($urandom);
		it.start_offset  = 9'($urandom);
		it.packet_length = 10'($urandom);
		return it;
	endfunction

	function automatic plan_row_t plan_row(row_kind_t kind, logic [1:0] command,
			logic [8:0] waddr, logic [7:0] bval, logic [8:0] start,
			logic [9:0] plen, logic [9:0] stop_at);
		plan_row_t r;
		r.kind                = kind;
		r.item.command        = command;
		r.item.write_address  = waddr;
		r.item.byte_value     = bval;
		r.item.start_offset   = start;
		r.item.packet_length  = plen;
		r.typed.name_char     = 8'h00;
		r.typed.char_valid    = 1'b0;
		r.typed.is_last       = 1'b1;
		r.typed.next_offset   = stop_at;
		r.typed.name_length   = '0;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// walker: updates the store on a write, queues the results of a
	// decode or skip
	// ------------------------------------------------------------------
	task automatic apply_command(cmd_item_t it);
		int unsigned plen, pos, saved, nxt, jumps, k;
		bit          have_saved, done;
		logic [7:0]  lab;
		logic [7:0]  name_buf [$];
		res_item_t   r;

		plen = (it.packet_length > PACKET_BYTES) ? PACKET_BYTES : it.packet_length;
		r = '0;
		r.is_last = 1'b1;
		case (it.command)
			CMD_WRITE: begin
				// a 9-bit address always lands inside the store
				pkt_mem[it.write_address] = it.byte_value;
			end
			CMD_SKIP: begin
				pos  = it.start_offset;
				nxt  = plen;      // ran off the packet
				done = 1'b0;
				while (!done && pos < plen) begin
					lab = mem_byte(pos);
					if (lab == 8'h00) begin
						nxt  = pos + 1;
						done = 1'b1;
					end else if ((lab & PTR_MARK) == PTR_MARK) begin
						nxt  = pos + 2;
						done = 1'b1;
					end else begin
						pos += 1 + lab;
					end
				end
				r.next_offset = nxt[NEXT_W-1:0];
				pending_chars.push_back(r);
			end
			CMD_DECODE: begin
				pos        = it.start_offset;
				jumps      = 0;
				saved      = 0;
				have_saved = 1'b0;
				done       = 1'b0;
				while (!done && pos < plen && jumps < MAX_JUMPS) begin
					lab = mem_byte(pos);
					if (lab == 8'h00) begin
						pos++;
						done = 1'b1;
					end else if ((lab & PTR_MARK) == PTR_MARK) begin
						if (!have_saved) begin
							saved      = pos + 2;
							have_saved = 1'b1;
						end
						// second byte may sit past the packet end
						pos = {lab[5:0], mem_byte(pos + 1)};
						jumps++;
					end else begin
						// top bits 01 and 10 are plain lengths here
						pos++;
						if (name_buf.size() > 0 && name_buf.size() < CHAR_LIMIT)
							name_buf.push_back(DOT_CHAR);
						// a label cut at the limit is not skipped: the walk
						// reads on from the cut point as a length byte
						for (k = 0; k < lab && pos < plen && name_buf.size() < CHAR_LIMIT;
								k++) begin
							name_buf.push_back(mem_byte(pos));
							pos++;
						end
					end
				end
				nxt = have_saved ? saved : pos;
				if (name_buf.size() == 0) begin
					r.next_offset = nxt[NEXT_W-1:0];
					pending_chars.push_back(r);
				end else begin
					if (name_buf.size() > longest_name)
						longest_name = name_buf.size();
					foreach (name_buf[n]) begin
						r            = '0;
						r.name_char  = name_buf[n];
						r.char_valid = 1'b1;
						if (n == name_buf.size() - 1) begin
							r.is_last     = 1'b1;
							r.next_offset = nxt[NEXT_W-1:0];
							r.name_length = OLEN_W'(name_buf.size());
						end
						pending_chars.push_back(r);
					end
				end
			end
			default: ;    // unused command: nothing happens
		endcase
	endtask

	// one command transaction; valid stays up across back-to-back items
	task automatic drive_cmd(cmd_item_t it);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= it;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		case (it.command)
			CMD_WRITE:  writes_sent++;
			CMD_DECODE: decodes_sent++;
			CMD_SKIP:   skips_sent++;
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// result side: random stall, stretches of none while calm
	// ------------------------------------------------------------------
	initial begin
		int n;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = idle_len();
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// every accepted result against the oldest owed one, field by field
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			results_checked++;
			if (pending_chars.size() == 0) begin
				flag_mismatch($sformatf("unexpected result, char %02h last %0b",
					res_data.name_char, res_data.is_last));
			end else begin
				want = pending_chars.pop_front();
				if (res_data.name_char !== want.name_char)
					flag_mismatch($sformatf("result %0d name_char %02h, want %02h",
						results_checked, res_data.name_char, want.name_char));
				if (res_data.char_valid !== want.char_valid)
					flag_mismatch($sformatf("result %0d char_valid %0b, want %0b",
						results_checked, res_data.char_valid, want.char_valid));
				if (res_data.is_last !== want.is_last)
					flag_mismatch($sformatf("result %0d is_last %0b, want %0b",
						results_checked, res_data.is_last, want.is_last));
				if (res_data.next_offset !== want.next_offset)
					flag_mismatch($sformatf("result %0d next_offset %0d, want %0d",
						results_checked, res_data.next_offset, want.next_offset));
				if (res_data.name_length !== want.name_length)
					flag_mismatch($sformatf("result %0d name_length %0d, want %0d",
						results_checked, res_data.name_length, want.name_length));
			end
		end
	end

	// run limit: covers the clearing pass and worst-case stalls many times
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycle_count, pending_chars.size());
			$display("dns_name_decompressor_core verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		int unsigned base, at, tgt, nlab, llen, wlen, roll, random_fed;
		cmd_item_t   it;
		int unsigned name_bases [$];

		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_data  = '0;
		for (int a = 0; a < PACKET_BYTES; a++)
			pkt_mem[a] = 8'h00;

		// directed table; typed rows need no walker
		// blank store: a zero length byte ends the name at once
		plan.push_back(plan_row(ROW_TYPED, CMD_DECODE, 9'h1FF, 8'hFF, 9'd0, 10'd512, 10'd1));
		// length above the store saturates
		plan.push_back(plan_row(ROW_TYPED, CMD_SKIP, 9'd0, 8'd0, 9'd0, 10'h3FF, 10'd1));
		// empty packet: walk never starts, stops at the start offset
		plan.push_back(plan_row(ROW_TYPED, CMD_DECODE, 9'd0, 8'd0, 9'd300, 10'd0, 10'd300));
		// unused command with every field at its top value
		plan.push_back(plan_row(ROW_SILENT, CMD_UNUSED, 9'h1FF, 8'hFF, 9'h1FF, 10'h3FF,
			10'd0));
		// "ab" at 0
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd0, 8'd2, 9'd0, 10'd0, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd1, 8'h61, 9'd0, 10'd0, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd2, 8'h62, 9'd0, 10'd0, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd3, 8'h00, 9'd0, 10'd0, 10'd0));
		// "x" then a pointer back to 0
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd4, 8'd1, 9'd0, 10'd0, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd5, 8'h78, 9'd0, 10'd0, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd6, 8'hC0, 9'd0, 10'd0, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd7, 8'h00, 9'd0, 10'd0, 10'd0));
		// pointer to 511, past a short packet
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd8, 8'hC1, 9'd0, 10'd0, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd9, 8'hFF, 9'd0, 10'd0, 10'd0));
		// pointer to itself: runs into the jump limit
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd10, 8'hC0, 9'd0, 10'd0, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd11, 8'h0A, 9'd0, 10'd0, 10'd0));
		// pointer in the last byte; its second byte is off the store
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'h1FF, 8'hC0, 9'd0, 10'd0, 10'd0));
		// length 0x7F (top bits 01) over zero bytes: hits the output cut
		plan.push_back(plan_row(ROW_MODEL, CMD_WRITE, 9'd100, 8'h7F, 9'd0, 10'd0, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_DECODE, 9'd0, 8'd0, 9'd0, 10'd512, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_DECODE, 9'd0, 8'd0, 9'd4, 10'd512, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_DECODE, 9'd0, 8'd0, 9'h1FF, 10'd512, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_SKIP, 9'd0, 8'd0, 9'd4, 10'd512, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_DECODE, 9'd0, 8'd0, 9'd8, 10'd100, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_DECODE, 9'd0, 8'd0, 9'd10, 10'd512, 10'd0));
		plan.push_back(plan_row(ROW_MODEL, CMD_DECODE, 9'd0, 8'd0, 9'd100, 10'd1000,
			10'd0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// commands may queue up while the store clears
		foreach (plan[p]) begin
			drive_cmd(plan[p].item);
			case (plan[p].kind)
				ROW_MODEL:  apply_command(plan[p].item);
				ROW_TYPED:  pending_chars.push_back(plan[p].typed);
				default: ;
			endcase
		end
		name_bases.push_back(0);
		name_bases.push_back(4);

		// random: mostly well-formed names, some noise
		random_fed = 0;
		while (random_fed < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				calm = ~calm;
			if ($urandom_range(0, 6) == 0) begin
				// noise: anything the fields allow
				it = random_fields();
				drive_cmd(it);
				apply_command(it);
				if (it.command != CMD_UNUSED)
					random_fed++;
			end else begin
				base = $urandom_range(0, 440);
				at   = base;
				nlab = $urandom_range(0, 4);
				for (int l = 0; l < nlab; l++) begin
					llen = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 63)
					                                   : $urandom_range(1, 8);
					wlen = llen;
					// now and then a length with top bits 01 or 10
					if ($urandom_range(0, 15) == 0) begin
						llen = $urandom_range(8'h40, 8'hBF);
						wlen = $urandom_range(0, 6);
					end
					it = random_fields();
					it.command       = CMD_WRITE;
					it.write_address = 9'(at);
					it.byte_value    = 8'(llen);
					drive_cmd(it);
					apply_command(it);
					random_fed++;
					at++;
					for (int c = 0; c < wlen; c++) begin
						it = random_fields();
						it.command       = CMD_WRITE;
						it.write_address = 9'(at);
						drive_cmd(it);
						apply_command(it);
						random_fed++;
						at++;
					end
				end
				// end of name: terminator, pointer back, or wild pointer
				roll = $urandom_range(0, 19);
				if (roll < 13) begin
					it = random_fields();
					it.command       = CMD_WRITE;
					it.write_address = 9'(at);
					it.byte_value    = 8'h00;
					drive_cmd(it);
					apply_command(it);
					random_fed++;
					at++;
				end else begin
					tgt = (roll < 18) ? name_bases[$urandom_range(0, name_bases.size() - 1)]
					                  : $urandom_range(0, 16383);
					it = random_fields();
					it.command       = CMD_WRITE;
					it.write_address = 9'(at);
					it.byte_value    = PTR_MARK | 8'(tgt >> 8);
					drive_cmd(it);
					apply_command(it);
					it = random_fields();
					it.command       = CMD_WRITE;
					it.write_address = 9'(at + 1);
					it.byte_value    = 8'(tgt);
					drive_cmd(it);
					apply_command(it);
					random_fed += 2;
					at += 2;
				end
				name_bases.push_back(base);

				// decode it, with the packet length mostly the full store
				it = random_fields();
				it.command      = CMD_DECODE;
				it.start_offset = 9'(base);
				roll = $urandom_range(0, 9);
				if (roll < 7)
					it.packet_length = 10'(PACKET_BYTES);
				else if (roll == 7)
					it.packet_length = 10'($urandom_range(513, 1023));
				else if (roll == 8)
					it.packet_length = 10'(at - $urandom_range(0, 2));
				drive_cmd(it);
				apply_command(it);
				random_fed++;
				if ($urandom_range(0, 2) == 0) begin
					it.command = CMD_SKIP;
					drive_cmd(it);
					apply_command(it);
					random_fed++;
				end
				// revisit an older name, which may chain through pointers
				if ($urandom_range(0, 1) == 0) begin
					it = random_fields();
					it.command       = CMD_DECODE;
					it.start_offset  = 9'(name_bases[$urandom_range(0, name_bases.size() - 1)]);
					it.packet_length = 10'(PACKET_BYTES);
					drive_cmd(it);
					apply_command(it);
					random_fed++;
				end
			end
		end
		cmd_valid <= 1'b0;
		calm = 1'b0;

		// drain, then give stray results time to show up
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", pending_chars.size()));

		$display("covered %0d byte writes, %0d decodes, %0d skips in %0d cycles",
			writes_sent, decodes_sent, skips_sent, cycle_count);
		$display("checked %0d results, longest name %0d chars, %0d mismatches",
			results_checked, longest_name, mismatches);
		if (mismatches == 0) begin
			$display("dns_name_decompressor_core verification clean");
		end else begin
			$display("dns_name_decompressor_core verification failed");
		end
		$finish;
	end

endmodule
